### rtl/core/topt_pkg.sv
package topt_pkg;

    localparam logic [31:0] MAGIC_RESET   = 32'h5566_7788;
    localparam logic [3:0]  DEMO_FIELDS   = 4'd10;
    localparam logic [15:0] DEMO_TRAIL    = 16'd104;
    localparam logic [15:0] END_ID        = 16'hFFFF;
    localparam logic [15:0] DEMO_ID       = 16'h0000;
    localparam logic [15:0] OPT_HDR_BYTES = 16'd4;
    localparam logic [1:0]  LAST_BYTE     = 2'd3;

    localparam logic [3:0] CODE_STATE      = 4'd0;
    localparam logic [3:0] CODE_SEQ        = 4'd1;
    localparam logic [3:0] CODE_VISION     = 4'd2;
    localparam logic [3:0] CODE_DEMO_BASE  = 4'd3;
    localparam logic [3:0] CODE_BAD_HEADER = 4'd13;
    localparam logic [3:0] CODE_END        = 4'd14;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QLW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  field_code;
        logic [31:0] field_value;
    } out_item_t;

    // classified word record between front and back
    typedef struct packed {
        logic [3:0]  code;
        logic [31:0] word;
    } rec_t;

    typedef struct packed {
        logic           full;
        logic           not_empty;
        logic [QLW-1:0] level;
    } q_status_t;

    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_STATE  = 8'b0000_0010,
        PH_SEQ    = 8'b0000_0100,
        PH_VISION = 8'b0000_1000,
        PH_OPTHDR = 8'b0001_0000,
        PH_DEMO   = 8'b0010_0000,
        PH_SKIP   = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

endpackage

### rtl/core/topt_front.sv
module topt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  topt_pkg::in_item_t in_item,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    output logic               rec_valid,
    output topt_pkg::rec_t     rec
);
    import topt_pkg::*;

    phase_t      phase_reg, phase_next, phase_e;
    logic [1:0]  biw_reg, biw_next, biw_e;
    logic [31:0] acc_reg, acc_next, acc_e, acc_shift;
    logic [3:0]  dfi_reg, dfi_next, dfi_e;
    logic [15:0] skip_reg, skip_next, skip_e, skip_dec;
    logic [31:0] magic_reg;
    logic [15:0] opt_id, opt_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            biw_reg   <= '0;
            acc_reg   <= '0;
            dfi_reg   <= '0;
            skip_reg  <= '0;
            magic_reg <= MAGIC_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            biw_reg   <= biw_next;
            acc_reg   <= acc_next;
            dfi_reg   <= dfi_next;
            skip_reg  <= skip_next;
            if (cfg_wr_en)
            begin
                magic_reg <= cfg_wr_data;
            end
        end
    end

    // a first byte restarts the datagram before the byte is parsed
    always_comb
    begin
        if (in_item.first_byte)
        begin
            phase_e = PH_HEADER;
            biw_e   = '0;
            acc_e   = '0;
            dfi_e   = '0;
            skip_e  = '0;
        end
        else
        begin
            phase_e = phase_reg;
            biw_e   = biw_reg;
            acc_e   = acc_reg;
            dfi_e   = dfi_reg;
            skip_e  = skip_reg;
        end
    end

    assign acc_shift = {in_item.byte_value, acc_e[31:8]};
    assign opt_id    = acc_shift[15:0];
    assign opt_len   = acc_shift[31:16];
    assign skip_dec  = (skip_e != '0) ? 16'(skip_e - 16'd1) : '0;

    always_comb
    begin
        phase_next = phase_reg;
        biw_next   = biw_reg;
        acc_next   = acc_reg;
        dfi_next   = dfi_reg;
        skip_next  = skip_reg;
        rec_valid  = 1'b0;
        rec.code   = CODE_STATE;
        rec.word   = acc_shift;
        if (take)
        begin
            phase_next = phase_e;
            biw_next   = biw_e;
            acc_next   = acc_e;
            dfi_next   = dfi_e;
            skip_next  = skip_e;
            case (phase_e)
                PH_DONE:
                begin
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_OPTHDR;
                        biw_next   = '0;
                    end
                end
                default:
                begin
                    acc_next = acc_shift;
                    if (biw_e != LAST_BYTE)
                    begin
                        biw_next = 2'(biw_e + 2'd1);
                    end
                    else
                    begin
                        biw_next = '0;
                        case (phase_e)
                            PH_HEADER:
                            begin
                                if (acc_shift != magic_reg)
                                begin
                                    phase_next = PH_DONE;
                                    rec_valid  = 1'b1;
                                    rec.code   = CODE_BAD_HEADER;
                                end
                                else
                                begin
                                    phase_next = PH_STATE;
                                end
                            end
                            PH_STATE:
                            begin
                                phase_next = PH_SEQ;
                                rec_valid  = 1'b1;
                                rec.code   = CODE_STATE;
                            end
                            PH_SEQ:
                            begin
                                phase_next = PH_VISION;
                                rec_valid  = 1'b1;
                                rec.code   = CODE_SEQ;
                            end
                            PH_VISION:
                            begin
                                phase_next = PH_OPTHDR;
                                rec_valid  = 1'b1;
                                rec.code   = CODE_VISION;
                            end
                            PH_OPTHDR:
                            begin
                                if (opt_id == DEMO_ID)
                                begin
                                    phase_next = PH_DEMO;
                                    dfi_next   = '0;
                                end
                                else if (opt_id == END_ID)
                                begin
                                    phase_next = PH_DONE;
                                    rec_valid  = 1'b1;
                                    rec.code   = CODE_END;
                                end
                                else if (opt_len > OPT_HDR_BYTES)
                                begin
                                    phase_next = PH_SKIP;
                                    skip_next  = 16'(opt_len - OPT_HDR_BYTES);
                                end
                                else
                                begin
                                    phase_next = PH_OPTHDR;
                                end
                            end
                            PH_DEMO:
                            begin
                                rec_valid = 1'b1;
                                rec.code  = 4'(CODE_DEMO_BASE + dfi_e);
                                if (dfi_e >= 4'(DEMO_FIELDS - 4'd1))
                                begin
                                    dfi_next   = '0;
                                    skip_next  = DEMO_TRAIL;
                                    phase_next = PH_SKIP;
                                end
                                else
                                begin
                                    dfi_next = 4'(dfi_e + 4'd1);
                                end
                            end
                            default:
                            begin
                                phase_next = PH_DONE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

### rtl/core/topt_queue.sv
module topt_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  topt_pkg::rec_t       wr_rec,
    input  logic                 rd_en,
    output topt_pkg::rec_t       rd_rec,
    output topt_pkg::q_status_t  status
);
    import topt_pkg::*;

    rec_t           slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLW-1:0] level_reg, level_next;
    logic           do_wr, do_rd;

    assign do_wr = wr_en && (level_reg != QLW'(QDEPTH));
    assign do_rd = rd_en && (level_reg != '0);

    assign wr_ptr_next = do_wr ? QAW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
    assign rd_ptr_next = do_rd ? QAW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;

    always_comb
    begin
        level_next = level_reg;
        if (do_wr && !do_rd)
        begin
            level_next = QLW'(level_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            level_next = QLW'(level_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    assign rd_rec = slot_reg[rd_ptr_reg];
    assign status = '{full:      (level_reg == QLW'(QDEPTH)),
                      not_empty: (level_reg != '0),
                      level:     level_reg};

endmodule

### rtl/core/topt_back.sv
module topt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  topt_pkg::rec_t       rec,
    input  logic                 rec_avail,
    output logic                 rec_take,
    input  logic                 pop,
    output logic                 empty,
    output topt_pkg::out_item_t  out_item
);
    import topt_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t out_reg, out_next;
    logic      no_value;

    assign rec_take = rec_avail && (!valid_reg || pop);

    // bad-header and end markers carry no word
    assign no_value = (rec.code == CODE_BAD_HEADER) || (rec.code == CODE_END);

    always_comb
    begin
        out_next.field_code  = rec.code;
        out_next.field_value = no_value ? '0 : rec.word;
        if (rec_take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            out_reg <= out_next;
        end
    end

    assign empty    = !valid_reg;
    assign out_item = out_reg;

endmodule

### rtl/core/telemetry_option_parser_core.sv
// One byte per cycle while full is low; full rises only when the 4-entry word queue fills.
// The byte parser decides in the accepting cycle and its record is written to the queue;
// the output register is loaded from the queue while it is empty or being popped.
// Reset (rst_n low, async): header phase, queue and output empty, magic = 0x55667788.
// No clearing pass: items are taken from the first edge after reset.
module telemetry_option_parser_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  topt_pkg::in_item_t   in_item,
    output logic                 empty,
    input  logic                 pop,
    output topt_pkg::out_item_t  out_item,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data
);
    import topt_pkg::*;

    logic      take;
    logic      rec_valid;
    rec_t      front_rec;
    rec_t      q_rec;
    logic      q_take;
    q_status_t q_stat;

    assign full = q_stat.full;
    assign take = push && !q_stat.full;

    topt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rec_valid   (rec_valid),
        .rec         (front_rec)
    );

    topt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (rec_valid),
        .wr_rec (front_rec),
        .rd_en  (q_take),
        .rd_rec (q_rec),
        .status (q_stat)
    );

    topt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (q_rec),
        .rec_avail (q_stat.not_empty),
        .rec_take  (q_take),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= QLW'(QDEPTH))
        else $error("queue level above depth");

    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.not_empty && empty) |=> !empty)
        else $error("output register not refilled from queue");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("waiting result changed without pop");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !take)
        else $error("byte taken while queue full");

endmodule

### dv/tb_telemetry_option_parser_core.sv
module tb_telemetry_option_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import topt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    in_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   out_item;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    telemetry_option_parser_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser state mirror
    phase_t      p_phase = PH_HEADER;
    logic [1:0]  p_pos = '0;
    logic [31:0] p_shift = '0;
    logic [3:0]  p_demo_n = '0;
    logic [15:0] p_skip_left = '0;
    logic [31:0] p_magic = MAGIC_RESET;

    out_item_t   expected_fields[$];
    out_item_t   want_field;
    int          errors = 0;
    int          items_sent = 0;
    int          cut_left = -1;
    int          rx_hold = 0;
    bit          steady = 1'b0;

    function automatic void queue_field(input logic [3:0] code, input logic [31:0] value);
        out_item_t f;
        f.field_code  = code;
        f.field_value = value;
        expected_fields.push_back(f);
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic starts);
        logic [31:0] w;
        logic [15:0] id;
        logic [15:0] len;
        if (starts)
        begin
            p_phase     = PH_HEADER;
            p_pos       = '0;
            p_shift     = '0;
            p_demo_n    = '0;
            p_skip_left = '0;
        end
        if (p_phase == PH_DONE)
            return;
        if (p_phase == PH_SKIP)
        begin
            if (p_skip_left != 0)
                p_skip_left--;
            if (p_skip_left == 0)
            begin
                p_phase = PH_OPTHDR;
                p_pos   = '0;
            end
            return;
        end
        p_shift = {b, p_shift[31:8]};
        if (p_pos != LAST_BYTE)
        begin
            p_pos++;
            return;
        end
        p_pos = '0;
        w = p_shift;
        case (p_phase)
            PH_HEADER:
            begin
                if (w != p_magic)
                begin
                    p_phase = PH_DONE;
                    queue_field(CODE_BAD_HEADER, '0);
                end
                else
                    p_phase = PH_STATE;
            end
            PH_STATE:
            begin
                p_phase = PH_SEQ;
                queue_field(CODE_STATE, w);
            end
            PH_SEQ:
            begin
                p_phase = PH_VISION;
                queue_field(CODE_SEQ, w);
            end
            PH_VISION:
            begin
                p_phase = PH_OPTHDR;
                queue_field(CODE_VISION, w);
            end
            PH_OPTHDR:
            begin
                id  = w[15:0];
                len = w[31:16];
                if (id == DEMO_ID)
                begin
                    p_phase  = PH_DEMO;
                    p_demo_n = '0;
                end
                else if (id == END_ID)
                begin
                    p_phase = PH_DONE;
                    queue_field(CODE_END, '0);
                end
                else if (len > OPT_HDR_BYTES)
                begin
                    p_skip_left = len - OPT_HDR_BYTES;
                    p_phase     = PH_SKIP;
                end
            end
            PH_DEMO:
            begin
                queue_field(CODE_DEMO_BASE + p_demo_n, w);
                if (p_demo_n == DEMO_FIELDS - 4'd1)
                begin
                    p_demo_n    = '0;
                    p_skip_left = DEMO_TRAIL;
                    p_phase     = PH_SKIP;
                end
                else
                    p_demo_n++;
            end
            default:
                p_phase = PH_DONE;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic starts);
        while (!steady && $urandom_range(99) < 38)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= '{byte_value: b, first_byte: starts};
        @(posedge clk);
        while (full)
            @(posedge clk);
        parse_byte(b, starts);
        items_sent++;
    endtask

    // cut_left truncates the current datagram; -1 means no cut
    task automatic pkt_byte(input logic [7:0] b, input logic starts);
        if (cut_left == 0)
            return;
        if (cut_left > 0)
            cut_left--;
        send_byte(b, starts);
    endtask

    task automatic send_word(input logic [31:0] w, input logic starts);
        pkt_byte(w[7:0], starts);
        pkt_byte(w[15:8], 1'b0);
        pkt_byte(w[23:16], 1'b0);
        pkt_byte(w[31:24], 1'b0);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_magic(input logic [31:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        p_magic = v;
    endtask

    // clean: good header, one demo option, end option
    task automatic send_packet(input bit clean);
        int          n_opts;
        int          r;
        int          len;
        int          k;
        int          i;
        logic [15:0] id;
        cut_left = -1;
        if (!clean && $urandom_range(99) < 10)
            cut_left = $urandom_range(1, 80);
        if (!clean && $urandom_range(99) < 10)
        begin
            send_word(p_magic ^ (32'h1 << $urandom_range(31)), 1'b1);
            repeat ($urandom_range(0, 6)) pkt_byte(8'($urandom), 1'b0);
            cut_left = -1;
            return;
        end
        send_word(p_magic, 1'b1);
        repeat (3) send_word($urandom, 1'b0);
        n_opts = clean ? 1 : $urandom_range(1, 4);
        for (k = 0; k < n_opts; k++)
        begin
            r = clean ? 0 : $urandom_range(99);
            if (r < 40)
            begin
                send_word({16'($urandom), DEMO_ID}, 1'b0);
                repeat (DEMO_FIELDS) send_word($urandom, 1'b0);
                repeat (DEMO_TRAIL) pkt_byte(8'($urandom), 1'b0);
            end
            else
            begin
                id = 16'($urandom_range(1, 16'hFFFE));
                r = $urandom_range(99);
                if (r < 20)
                    len = $urandom_range(0, 4);
                else if (r < 90)
                    len = $urandom_range(5, 24);
                else if (r < 96)
                    len = $urandom_range(256, 300);
                else
                begin
                    // huge option, abandoned by the next datagram start
                    len = $urandom_range(16'hF000, 16'hFFFF);
                    if (cut_left < 0 || cut_left > 60)
                        cut_left = $urandom_range(8, 60);
                end
                send_word({16'(len), id}, 1'b0);
                for (i = 4; i < len && cut_left != 0; i++)
                    pkt_byte(8'($urandom), 1'b0);
            end
        end
        send_word({16'($urandom), END_ID}, 1'b0);
        repeat ($urandom_range(0, 3)) pkt_byte(8'($urandom), 1'b0);
        cut_left = -1;
    endtask

    task automatic test_directed();
        send_word(32'h0000_0000, 1'b0);
        pkt_byte(8'hFF, 1'b0);
        send_word(MAGIC_RESET, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8000_0001, 1'b0);
        send_word({16'h0000, END_ID}, 1'b0);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (3) send_packet(1'b1);
        repeat (2) send_packet(1'b0);
        steady = 1'b0;
    endtask

    task automatic test_receiver_stall();
        rx_hold <= 400;
        repeat (2) send_packet(1'b1);
    endtask

    task automatic test_header_magic();
        logic [31:0] values[4];
        int          k;
        values[0] = 32'h0000_0000;
        values[1] = 32'hFFFF_FFFF;
        values[2] = $urandom;
        values[3] = MAGIC_RESET;
        for (k = 0; k < 4; k++)
        begin
            write_magic(values[k]);
            send_word(values[k], 1'b1);
            repeat (3) send_word($urandom, 1'b0);
            send_word({16'($urandom), END_ID}, 1'b0);
            send_word(~values[k], 1'b1);
            pkt_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic test_random_traffic();
        int start;
        start = items_sent;
        while (items_sent < 1700 || items_sent - start < 300)
        begin
            if ($urandom_range(99) < 6)
                repeat ($urandom_range(1, 12))
                    pkt_byte(8'($urandom), $urandom_range(9) == 0);
            else
                send_packet(1'b0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
            pop <= 1'b0;
        end
        else
            pop <= steady || ($urandom_range(99) >= 38);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_fields.size() == 0)
            begin
                $error("unexpected item: field_code %0d field_value %h",
                       out_item.field_code, out_item.field_value);
                errors++;
            end
            else
            begin
                want_field = expected_fields.pop_front();
                if (out_item.field_code !== want_field.field_code)
                begin
                    $error("field_code expected %0d actual %0d",
                           want_field.field_code, out_item.field_code);
                    errors++;
                end
                if (out_item.field_value !== want_field.field_value)
                begin
                    $error("field_value expected %h actual %h",
                           want_field.field_value, out_item.field_value);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL telemetry_option_parser_core");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_back_to_back();
        test_receiver_stall();
        test_header_magic();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("PASS telemetry_option_parser_core");
        else
            $display("FAIL telemetry_option_parser_core");
        $finish;
    end

endmodule
